@@ src/mtm_pkg.sv @@
`timescale 1ns / 1ps
package mtm_pkg;

	localparam int TILE_DIM = 3;
	localparam int IDX_W = 2;
	localparam int FIELD_W = 16;
	localparam int C_WIDTH = 48;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_UPDATE = 2'd1,
		OP_DRAIN  = 2'd2
	} op_t;

	typedef struct packed {
		logic             valid;
		op_t              opcode;
		logic [IDX_W-1:0] tile_row;
		logic [IDX_W-1:0] tile_col;
	} ctrl_t;

endpackage

@@ src/mtm_cell.sv @@
`timescale 1ns / 1ps
module mtm_cell import mtm_pkg::*; #(
	parameter int DATA_WIDTH = 16,
	parameter int ACC_WIDTH = 48,
	parameter int ROW = 0
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  ctrl_t                                ctrl_in,
	input  logic [TILE_DIM-1:0][DATA_WIDTH-1:0]  a_in,
	input  logic [TILE_DIM-1:0][DATA_WIDTH-1:0]  b_in,
	input  logic [C_WIDTH-1:0]                   c_old_in,
	input  logic [ACC_WIDTH-1:0]                 acc_in,
	output ctrl_t                                ctrl_out,
	output logic [TILE_DIM-1:0][DATA_WIDTH-1:0]  a_out,
	output logic [TILE_DIM-1:0][DATA_WIDTH-1:0]  b_out,
	output logic [C_WIDTH-1:0]                   c_old_out,
	output logic [ACC_WIDTH-1:0]                 acc_out
);

	localparam int PROD_W = 2 * DATA_WIDTH;
	localparam int EXT_W = (PROD_W > ACC_WIDTH) ? PROD_W : ACC_WIDTH;

	ctrl_t                               ctrl_s1;
	logic [TILE_DIM-1:0][DATA_WIDTH-1:0] a_s1;
	logic [TILE_DIM-1:0][DATA_WIDTH-1:0] b_s1;
	logic [C_WIDTH-1:0]                  c_old_s1;
	logic [ACC_WIDTH-1:0]                acc_s1;
	logic signed [PROD_W-1:0]            prod_s1 [TILE_DIM];

	ctrl_t                               ctrl_s2;
	logic [TILE_DIM-1:0][DATA_WIDTH-1:0] a_s2;
	logic [TILE_DIM-1:0][DATA_WIDTH-1:0] b_s2;
	logic [C_WIDTH-1:0]                  c_old_s2;
	logic [ACC_WIDTH-1:0]                acc_s2;

	logic [ACC_WIDTH-1:0]                acc_q [TILE_DIM];
	logic [ACC_WIDTH-1:0]                prod_ext [TILE_DIM];
	logic [ACC_WIDTH-1:0]                acc_rd;
	logic                                drain_hit;

	// stage 1: this row's three products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else if (en) begin
			ctrl_s1 <= ctrl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1     <= a_in;
			b_s1     <= b_in;
			c_old_s1 <= c_old_in;
			acc_s1   <= acc_in;
			for (int c = 0; c < TILE_DIM; c++) begin
				prod_s1[c] <= $signed(a_in[ROW]) * $signed(b_in[c]);
			end
		end
	end

	always_comb begin
		logic signed [EXT_W-1:0] wide;
		for (int c = 0; c < TILE_DIM; c++) begin
			wide = EXT_W'(prod_s1[c]);
			prod_ext[c] = wide[ACC_WIDTH-1:0];
		end
	end

	always_comb begin
		case (ctrl_s1.tile_col)
			IDX_W'(0): acc_rd = acc_q[0];
			IDX_W'(1): acc_rd = acc_q[1];
			IDX_W'(2): acc_rd = acc_q[2];
			default:   acc_rd = '0;
		endcase
	end

	assign drain_hit = ctrl_s1.valid && (ctrl_s1.opcode == OP_DRAIN)
		&& (ctrl_s1.tile_row == IDX_W'(ROW));

	// stage 2: accumulate or clear, pick up the drained value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2 <= '0;
			for (int c = 0; c < TILE_DIM; c++) begin
				acc_q[c] <= '0;
			end
		end else if (en) begin
			ctrl_s2 <= ctrl_s1;
			if (ctrl_s1.valid) begin
				case (ctrl_s1.opcode)
					OP_CLEAR: begin
						for (int c = 0; c < TILE_DIM; c++) begin
							acc_q[c] <= '0;
						end
					end
					OP_UPDATE: begin
						for (int c = 0; c < TILE_DIM; c++) begin
							acc_q[c] <= acc_q[c] + prod_ext[c];
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s2     <= a_s1;
			b_s2     <= b_s1;
			c_old_s2 <= c_old_s1;
			acc_s2   <= drain_hit ? acc_rd : acc_s1;
		end
	end

	assign ctrl_out  = ctrl_s2;
	assign a_out     = a_s2;
	assign b_out     = b_s2;
	assign c_old_out = c_old_s2;
	assign acc_out   = acc_s2;

	a_clear_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		en && ctrl_s1.valid && ctrl_s1.opcode == OP_CLEAR
		|=> acc_q[0] == '0 && acc_q[1] == '0 && acc_q[2] == '0)
		else $error("accumulators not cleared");

	a_drain_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		en && ctrl_s1.valid && ctrl_s1.opcode == OP_DRAIN
		|=> acc_q[0] == $past(acc_q[0]) && acc_q[1] == $past(acc_q[1])
			&& acc_q[2] == $past(acc_q[2]))
		else $error("drain altered accumulators");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(acc_q[0]) && $stable(acc_q[1]) && $stable(acc_q[2])
			&& $stable(ctrl_s2))
		else $error("cell moved while stalled");

endmodule

@@ src/mtm_sat.sv @@
`timescale 1ns / 1ps
module mtm_sat import mtm_pkg::*; #(
	parameter int ACC_WIDTH = 48
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  ctrl_t                ctrl_in,
	input  logic [ACC_WIDTH-1:0] acc_in,
	input  logic [C_WIDTH-1:0]   c_old_in,
	output logic                 out_valid,
	output logic [C_WIDTH-1:0]   out_data
);

	localparam int SUM_W = ((ACC_WIDTH > C_WIDTH) ? ACC_WIDTH : C_WIDTH) + 1;

	logic signed [SUM_W-1:0] sum;
	logic signed [SUM_W-1:0] sat_hi;
	logic signed [SUM_W-1:0] sat_lo;
	logic [C_WIDTH-1:0]      sat_val;
	logic                    valid_q;
	logic [C_WIDTH-1:0]      data_q;

	always_comb begin
		sum = SUM_W'($signed(acc_in)) + SUM_W'($signed(c_old_in));
		sat_hi = {{(SUM_W-C_WIDTH+1){1'b0}}, {(C_WIDTH-1){1'b1}}};
		sat_lo = ~sat_hi;
		if (sum > sat_hi) begin
			sat_val = sat_hi[C_WIDTH-1:0];
		end else if (sum < sat_lo) begin
			sat_val = sat_lo[C_WIDTH-1:0];
		end else begin
			sat_val = sum[C_WIDTH-1:0];
		end
	end

	// only a drain item leaves a result; others drop here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= ctrl_in.valid && (ctrl_in.opcode == OP_DRAIN);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= sat_val;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

	a_valid_from_drain: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_q) |-> $past(ctrl_in.valid && ctrl_in.opcode == OP_DRAIN && en))
		else $error("result without drain item");

	a_sat_range: assert property (@(posedge clk) disable iff (!arst_n)
		en && ctrl_in.valid && ctrl_in.opcode == OP_DRAIN && sum > sat_hi
		|=> data_q == sat_hi[C_WIDTH-1:0])
		else $error("positive saturation missed");

endmodule

@@ src/matrix_tile_mac_3x3.sv @@
`timescale 1ns / 1ps
// 3x3 outer-product tile engine.
// Input channel s_*: tuser carries the opcode (clear, rank-1 update, drain);
// tdata carries the A column, the B row, the drain coordinates and c_old.
// Output channel m_*: one item per drain, tdata = c_old + accumulator,
// saturated to 48 bits. Clear and update items give no output item.
// Items run through a chain of three row cells; each cell owns the three
// accumulators of one tile row and takes an item through a product
// register, then an accumulate register, passing it to the next cell.
// A drain result passes through every cell, then the saturation output register.
// Throughput: one item per cycle while the output is not stalled, set by
// one pass through each cell's multiply and accumulate stages.
// When the receiver stalls a pending result, the whole chain holds and
// s_tready drops until the result is taken; nothing is lost.
// Reset clears all nine accumulators and empties the chain at once.
module matrix_tile_mac_3x3 import mtm_pkg::*; #(
	parameter int DATA_WIDTH = 16,
	parameter int ACC_WIDTH = 48
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// a_row0, a_row1, a_row2, b_col0, b_col1, b_col2, tile_row, tile_col, c_old
	input  logic [151:0] s_tdata,
	// opcode
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// c_new
	output logic [47:0]  m_tdata
);

	localparam int ROW_LSB = 6 * FIELD_W;
	localparam int COL_LSB = ROW_LSB + IDX_W;
	localparam int COLD_LSB = COL_LSB + IDX_W;

	logic                                en;
	ctrl_t                               ctrl_c [TILE_DIM+1];
	logic [TILE_DIM-1:0][DATA_WIDTH-1:0] a_c [TILE_DIM+1];
	logic [TILE_DIM-1:0][DATA_WIDTH-1:0] b_c [TILE_DIM+1];
	logic [C_WIDTH-1:0]                  c_old_c [TILE_DIM+1];
	logic [ACC_WIDTH-1:0]                acc_c [TILE_DIM+1];

	// advance the chain whenever the output register is free or being taken
	assign en = !m_tvalid || m_tready;
	assign s_tready = en;

	assign ctrl_c[0].valid    = s_tvalid && s_tready;
	assign ctrl_c[0].opcode   = op_t'(s_tuser);
	assign ctrl_c[0].tile_row = s_tdata[ROW_LSB +: IDX_W];
	assign ctrl_c[0].tile_col = s_tdata[COL_LSB +: IDX_W];
	assign c_old_c[0]         = s_tdata[COLD_LSB +: C_WIDTH];
	assign acc_c[0]           = '0;

	for (genvar i = 0; i < TILE_DIM; i++) begin : g_operand
		if (DATA_WIDTH <= FIELD_W) begin : g_low
			assign a_c[0][i] = s_tdata[FIELD_W*i +: DATA_WIDTH];
			assign b_c[0][i] = s_tdata[FIELD_W*(i+TILE_DIM) +: DATA_WIDTH];
		end else begin : g_wide
			assign a_c[0][i] = DATA_WIDTH'(s_tdata[FIELD_W*i +: FIELD_W]);
			assign b_c[0][i] = DATA_WIDTH'(s_tdata[FIELD_W*(i+TILE_DIM) +: FIELD_W]);
		end
	end

	for (genvar r = 0; r < TILE_DIM; r++) begin : g_cell
		mtm_cell #(
			.DATA_WIDTH(DATA_WIDTH),
			.ACC_WIDTH (ACC_WIDTH),
			.ROW       (r)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.ctrl_in  (ctrl_c[r]),
			.a_in     (a_c[r]),
			.b_in     (b_c[r]),
			.c_old_in (c_old_c[r]),
			.acc_in   (acc_c[r]),
			.ctrl_out (ctrl_c[r+1]),
			.a_out    (a_c[r+1]),
			.b_out    (b_c[r+1]),
			.c_old_out(c_old_c[r+1]),
			.acc_out  (acc_c[r+1])
		);
	end

	mtm_sat #(
		.ACC_WIDTH(ACC_WIDTH)
	) u_sat (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.ctrl_in  (ctrl_c[TILE_DIM]),
		.acc_in   (acc_c[TILE_DIM]),
		.c_old_in (c_old_c[TILE_DIM]),
		.out_valid(m_tvalid),
		.out_data (m_tdata)
	);

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input blocked without output stall");

endmodule

@@ tb/sv/matrix_tile_mac_3x3_tb.sv @@
`timescale 1ns / 1ps
module matrix_tile_mac_3x3_tb;
	import mtm_pkg::*;

	localparam logic [1:0] OP_SPARE = 2'd3;
	localparam logic [FIELD_W-1:0] D_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
	localparam logic [FIELD_W-1:0] D_MIN = {1'b1, {(FIELD_W-1){1'b0}}};
	localparam logic [C_WIDTH-1:0] C_MAX = {1'b0, {(C_WIDTH-1){1'b1}}};
	localparam logic [C_WIDTH-1:0] C_MIN = {1'b1, {(C_WIDTH-1){1'b0}}};
	localparam int RUN_UPDATES = 40;
	localparam int RAND_PER_PHASE = 270;

	typedef struct packed {
		logic [1:0]                  opc;
		logic [2:0][FIELD_W-1:0]     a_col;
		logic [2:0][FIELD_W-1:0]     b_row;
		logic [IDX_W-1:0]            row;
		logic [IDX_W-1:0]            col;
		logic [C_WIDTH-1:0]          c_old;
		logic                        fixed;
		logic [C_WIDTH-1:0]          c_new;
	} tile_item_t;

	logic         clk = 1'b0;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [151:0] s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [47:0]  m_tdata;

	logic [C_WIDTH-1:0] tile_acc [TILE_DIM*TILE_DIM];
	logic [C_WIDTH-1:0] c_new_q [$];
	tile_item_t         dir_rows [$];

	int unsigned tx_idle_pct;
	int unsigned rx_stall_pct;
	int unsigned n_items, n_upd, n_drain, n_clear, n_spare, n_sat;
	int unsigned n_results, n_mismatch, n_errors;

	matrix_tile_mac_3x3 dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #1 clk = ~clk;

	initial begin
		#5_000_000;
		$display("timeout with %0d results still pending", c_new_q.size());
		$display("FAILURE");
		$finish;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= rx_stall_pct);
	end

	// Sample at the falling edge: inputs only move at the rising edge.
	always @(negedge clk) begin : c_new_check
		logic [C_WIDTH-1:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			n_results++;
			if (c_new_q.size() == 0) begin
				n_errors++;
				$display("c_new %h arrived with nothing pending", m_tdata);
			end else begin
				want = c_new_q.pop_front();
				if (m_tdata !== want) begin
					n_mismatch++;
					n_errors++;
					if (n_mismatch <= 10)
						$display("c_new mismatch at result %0d: expected %h, got %h",
							n_results, want, m_tdata);
				end
			end
		end
	end

	task automatic tile_predict(input tile_item_t it, output bit has_res,
			output logic [C_WIDTH-1:0] res);
		logic signed [FIELD_W-1:0]   av, bv;
		logic signed [2*FIELD_W-1:0] prod;
		logic [C_WIDTH-1:0]          accv;
		logic [C_WIDTH:0]            sum;
		has_res = 1'b0;
		res = '0;
		case (it.opc)
			OP_CLEAR: begin
				for (int i = 0; i < TILE_DIM*TILE_DIM; i++)
					tile_acc[i] = '0;
			end
			OP_UPDATE: begin
				for (int r = 0; r < TILE_DIM; r++) begin
					for (int c = 0; c < TILE_DIM; c++) begin
						av = it.a_col[r];
						bv = it.b_row[c];
						prod = av * bv;
						tile_acc[r*TILE_DIM+c] = tile_acc[r*TILE_DIM+c] +
							{{(C_WIDTH-2*FIELD_W){prod[2*FIELD_W-1]}}, prod};
					end
				end
			end
			OP_DRAIN: begin
				// out-of-range coordinates read the accumulator as zero
				if (it.row < TILE_DIM && it.col < TILE_DIM)
					accv = tile_acc[it.row*TILE_DIM+it.col];
				else
					accv = '0;
				sum = {accv[C_WIDTH-1], accv} + {it.c_old[C_WIDTH-1], it.c_old};
				has_res = 1'b1;
				if (sum[C_WIDTH] != sum[C_WIDTH-1]) begin
					res = sum[C_WIDTH] ? C_MIN : C_MAX;
					n_sat++;
				end else begin
					res = sum[C_WIDTH-1:0];
				end
			end
			default: ;
		endcase
	endtask

	task automatic send_tile_item(input tile_item_t it);
		bit                 has_res;
		logic [C_WIDTH-1:0] res;
		if ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < tx_idle_pct)
				@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, it.c_old, it.col, it.row, it.b_row, it.a_col};
		s_tuser <= it.opc;
		do @(negedge clk); while (!s_tready);
		tile_predict(it, has_res, res);
		if (has_res)
			c_new_q.push_back(it.fixed ? it.c_new : res);
		n_items++;
		case (it.opc)
			OP_CLEAR:  n_clear++;
			OP_UPDATE: n_upd++;
			OP_DRAIN:  n_drain++;
			default:   n_spare++;
		endcase
		@(posedge clk);
	endtask

	function automatic logic [FIELD_W-1:0] rand_operand();
		case ($urandom_range(7))
			0: return D_MAX;
			1: return D_MIN;
			2: return '0;
			default: return FIELD_W'($urandom);
		endcase
	endfunction

	function automatic logic [IDX_W-1:0] rand_coord();
		return ($urandom_range(9) == 0) ? IDX_W'(TILE_DIM) : IDX_W'($urandom_range(2));
	endfunction

	function automatic tile_item_t rand_tile_item();
		tile_item_t         it;
		logic [C_WIDTH-1:0] off;
		int unsigned        pick;
		pick = $urandom_range(99);
		it.opc = (pick < 4) ? OP_CLEAR : (pick < 8) ? OP_SPARE :
			(pick < 60) ? OP_UPDATE : OP_DRAIN;
		for (int i = 0; i < TILE_DIM; i++) begin
			it.a_col[i] = rand_operand();
			it.b_row[i] = rand_operand();
		end
		it.row = rand_coord();
		it.col = rand_coord();
		// keep c_old near the rails often so the drain saturates both ways
		off = C_WIDTH'({$urandom, $urandom}) >> $urandom_range(47);
		case ($urandom_range(3))
			0: it.c_old = C_WIDTH'({$urandom, $urandom});
			1: it.c_old = C_MAX - off;
			2: it.c_old = C_MIN + off;
			default: it.c_old = $urandom_range(1) ? off : -off;
		endcase
		it.fixed = 1'b0;
		it.c_new = '0;
		return it;
	endfunction

	function automatic void add_row(input logic [1:0] opc,
			input logic [FIELD_W-1:0] a0, a1, a2, b0, b1, b2,
			input logic [IDX_W-1:0] row, col, input logic [C_WIDTH-1:0] c_old,
			input logic fixed, input logic [C_WIDTH-1:0] c_new);
		tile_item_t it;
		it.opc = opc;
		it.a_col = {a2, a1, a0};
		it.b_row = {b2, b1, b0};
		it.row = row;
		it.col = col;
		it.c_old = c_old;
		it.fixed = fixed;
		it.c_new = c_new;
		dir_rows.push_back(it);
	endfunction

	initial begin : stimulus
		tile_item_t it;
		int unsigned idle_tab [4] = '{0, 54, 0, 18};
		int unsigned stall_tab [4] = '{0, 0, 54, 18};
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		for (int i = 0; i < TILE_DIM*TILE_DIM; i++)
			tile_acc[i] = '0;

		// after reset every accumulator reads zero
		add_row(OP_DRAIN, 0, 0, 0, 0, 0, 0, 0, 0, '0, 1, '0);
		add_row(OP_DRAIN, 0, 0, 0, 0, 0, 0, 2, 2, C_MAX, 1, C_MAX);
		add_row(OP_DRAIN, D_MAX, D_MIN, 1, 2, 3, 4, 3, 0, -48'sd5, 1, -48'sd5);
		add_row(OP_DRAIN, 0, 0, 0, 0, 0, 0, 1, 3, C_MIN, 1, C_MIN);
		add_row(OP_DRAIN, 0, 0, 0, 0, 0, 0, 3, 3, 48'd123, 1, 48'd123);
		add_row(OP_UPDATE, D_MIN, D_MIN, D_MIN, D_MIN, D_MIN, D_MIN, 0, 0, '0, 0, '0);
		add_row(OP_DRAIN, 0, 0, 0, 0, 0, 0, 0, 1, C_MAX, 1, C_MAX);
		add_row(OP_DRAIN, 0, 0, 0, 0, 0, 0, 1, 2, '0, 1, 48'h0000_4000_0000);
		add_row(OP_SPARE, D_MAX, D_MAX, D_MAX, D_MAX, D_MAX, D_MAX, 1, 1, C_MAX, 0, '0);
		add_row(OP_DRAIN, 0, 0, 0, 0, 0, 0, 1, 1, '0, 1, 48'h0000_4000_0000);
		add_row(OP_CLEAR, D_MAX, D_MIN, D_MAX, D_MIN, D_MAX, D_MIN, 2, 2, C_MAX, 0, '0);
		add_row(OP_DRAIN, 0, 0, 0, 0, 0, 0, 2, 0, 48'd7, 1, 48'd7);
		add_row(OP_UPDATE, D_MAX, D_MIN, 0, D_MIN, D_MAX, 1, 0, 0, '0, 0, '0);
		add_row(OP_UPDATE, D_MAX, D_MAX, D_MAX, D_MIN, D_MIN, D_MIN, 0, 0, '0, 0, '0);
		add_row(OP_DRAIN, 0, 0, 0, 0, 0, 0, 0, 0, C_MIN, 1, C_MIN);
		add_row(OP_DRAIN, 0, 0, 0, 0, 0, 0, 1, 1, '0, 0, '0);
		add_row(OP_DRAIN, 0, 0, 0, 0, 0, 0, 2, 2, '0, 0, '0);
		add_row(OP_DRAIN, 0, 0, 0, 0, 0, 0, 0, 2, C_MIN + 1, 0, '0);
		add_row(OP_DRAIN, 0, 0, 0, 0, 0, 0, 2, 1, C_MAX, 0, '0);
		add_row(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, '0, 0, '0);
		add_row(OP_DRAIN, 0, 0, 0, 0, 0, 0, 2, 2, '0, 1, '0);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int ph = 0; ph < 4; ph++) begin
			tx_idle_pct = idle_tab[ph];
			rx_stall_pct = stall_tab[ph];
			if (ph == 0) begin
				foreach (dir_rows[i])
					send_tile_item(dir_rows[i]);
				// pile a long run of the largest products into every accumulator
				add_row(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, '0, 0, '0);
				send_tile_item(dir_rows[$]);
				it = dir_rows[5];
				for (int n = 0; n < RUN_UPDATES; n++)
					send_tile_item(it);
				it = rand_tile_item();
				it.opc = OP_DRAIN;
				it.row = 0;
				it.col = 0;
				it.c_old = '0;
				send_tile_item(it);
				it.row = 2;
				it.col = 1;
				it.c_old = C_MIN;
				send_tile_item(it);
			end
			for (int n = 0; n < RAND_PER_PHASE; n++)
				send_tile_item(rand_tile_item());
		end
		s_tvalid <= 1'b0;

		while (c_new_q.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		$display("Sent %0d items: %0d updates, %0d drains, %0d clears, %0d unused opcodes",
			n_items, n_upd, n_drain, n_clear, n_spare);
		$display("Checked %0d results (%0d saturated), %0d errors over four idle/stall mixes",
			n_results, n_sat, n_errors);
		if (n_errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

@@ sim.f @@
src/mtm_pkg.sv
src/mtm_cell.sv
src/mtm_sat.sv
src/matrix_tile_mac_3x3.sv
tb/sv/matrix_tile_mac_3x3_tb.sv
